/* rtl/core/cha_pkg.sv */
// package: shared types and constants for the chained hash accumulator
package cha_pkg;

  localparam int IdHighW = 64;
  localparam int IdMidW = 64;
  localparam int IdLowW = 16;
  localparam int DistW = 16;
  localparam int TotalW = 32;
  localparam int BcntW = 11;
  localparam int SumW = 10;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    REG_MIN_DISTANCE = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_NODE_RD,
    S_NODE_WAIT,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IdHighW-1:0] id_high;
    logic [IdMidW-1:0] id_mid;
    logic [IdLowW-1:0] id_low;
  } key_t;

  typedef struct packed {
    logic operation;
    key_t key;
    logic [DistW-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [TotalW-1:0] total;
  } out_item_t;

endpackage

/* rtl/core/cha_if.sv */
// interfaces: valid/ready channels for input items and results
interface cha_in_if;
  import cha_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [IdHighW-1:0] id_high;
  logic [IdMidW-1:0] id_mid;
  logic [IdLowW-1:0] id_low;
  logic [DistW-1:0] distance;
  modport source(output valid, operation, id_high, id_mid, id_low, distance, input ready);
  modport sink(input valid, operation, id_high, id_mid, id_low, distance, output ready);
endinterface

interface cha_out_if;
  import cha_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [TotalW-1:0] total;
  modport source(output valid, status, total, input ready);
  modport sink(input valid, status, total, output ready);
endinterface

/* rtl/core/cha_node_mem.sv */
// node memory: keys, totals and links, one read and one write port
module cha_node_mem #(
  parameter int NODES = 4096,
  parameter int AW = 12,
  parameter int LW = 13
) (
  input  logic clk,
  input  logic rd_en,
  input  logic [AW-1:0] rd_addr,
  output cha_pkg::key_t rd_key,
  output logic [cha_pkg::TotalW-1:0] rd_total,
  output logic [LW-1:0] rd_link,
  input  logic wr_en,
  input  logic wr_key_en,
  input  logic [AW-1:0] wr_addr,
  input  cha_pkg::key_t wr_key,
  input  logic [cha_pkg::TotalW-1:0] wr_total,
  input  logic [LW-1:0] wr_link
);
  import cha_pkg::*;

  key_t key_mem [NODES];
  logic [TotalW-1:0] total_mem [NODES];
  logic [LW-1:0] link_mem [NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      total_mem[wr_addr] <= wr_total;
      if (wr_key_en) begin
        key_mem[wr_addr] <= wr_key;
        link_mem[wr_addr] <= wr_link;
      end
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_total <= total_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
    end
  end
endmodule

/* rtl/core/cha_head_mem.sv */
// bucket head memory with clearing pass after reset
module cha_head_mem #(
  parameter int BUCKETS = 1024,
  parameter int BW = 10,
  parameter int LW = 13
) (
  input  logic clk,
  input  logic rst,
  output logic clearing,
  input  logic rd_en,
  input  logic [BW-1:0] rd_addr,
  output logic [LW-1:0] rd_data,
  input  logic wr_en,
  input  logic [BW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data,
  input  logic [LW-1:0] empty_link
);
  logic [LW-1:0] head_mem [BUCKETS];
  logic [BW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == BW'(BUCKETS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      head_mem[clr_addr] <= empty_link;
    end else if (wr_en) begin
      head_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= head_mem[rd_addr];
    end
  end
endmodule

/* rtl/core/chained_hash_accumulator.sv */
// top level: keyed accumulator over a chained hash table
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    operation, id_high, id_mid, id_low, distance
//  out_ch    out  valid/ready    status, total
//  cfg       in   wr_en          wr_index, wr_data
//
// each item passes the hash, remainder, head read, chain walk, write and done states in that order.
// the hash remainder takes 10 compare and subtract steps, the node memory read port sets the walk.
// after reset a clearing pass empties every bucket head; no item is taken until it ends.
// the result waits in an output register; the next item is taken once it transfers.
module chained_hash_accumulator #(
  parameter int NODES = 4096,
  parameter int BUCKETS = 1024
) (
  input  logic clk,
  input  logic rst,
  cha_in_if.sink in_ch,
  cha_out_if.source out_ch,
  input  logic wr_en,
  input  logic wr_index,
  input  logic [cha_pkg::DistW-1:0] wr_data
);
  import cha_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int CW = (BCW > BcntW) ? BCW : BcntW;
  localparam int HW = (CW > SumW + 1) ? CW : SumW + 1;

  logic [DistW-1:0] min_distance;
  logic [BcntW-1:0] bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= '0;
      bucket_count <= BcntW'(1021);
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_MIN_DISTANCE: min_distance <= wr_data;
        REG_BUCKET_COUNT: bucket_count <= wr_data[BcntW-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  in_item_t item;
  logic [HW-1:0] hsum;
  logic [HW-1:0] eff;
  logic [3:0] mod_sh;
  logic [HW+SumW-1:0] eff_sh;
  logic [HW-1:0] hsum_rem;
  logic [BW-1:0] bucket;
  logic [LW-1:0] ptr;
  logic [LW-1:0] head_val;
  logic [LW-1:0] steps;
  logic [LW-1:0] nodes_used;
  logic [TotalW-1:0] new_total;
  logic found;
  logic out_valid;
  out_item_t out_item;

  logic clearing;
  logic head_rd_en, head_wr_en;
  logic [LW-1:0] head_rd_data;
  logic node_rd_en, node_wr_en, node_key_en;
  logic [AW-1:0] node_wr_addr;
  key_t rd_key;
  logic [TotalW-1:0] rd_total;
  logic [LW-1:0] rd_link;
  logic [LW-1:0] empty_link;
  logic [DistW-1:0] dist_eff;
  logic [TotalW:0] add_sum;
  logic [TotalW-1:0] sat_total;
  logic key_match;

  assign empty_link = LW'(NODES);

  cha_head_mem #(.BUCKETS(BUCKETS), .BW(BW), .LW(LW)) u_head (
    .clk, .rst, .clearing,
    .rd_en(head_rd_en), .rd_addr(bucket), .rd_data(head_rd_data),
    .wr_en(head_wr_en), .wr_addr(bucket), .wr_data(nodes_used),
    .empty_link
  );

  cha_node_mem #(.NODES(NODES), .AW(AW), .LW(LW)) u_node (
    .clk,
    .rd_en(node_rd_en), .rd_addr(ptr[AW-1:0]),
    .rd_key, .rd_total, .rd_link,
    .wr_en(node_wr_en), .wr_key_en(node_key_en), .wr_addr(node_wr_addr),
    .wr_key(item.key), .wr_total(new_total), .wr_link(head_val)
  );

  always_comb begin
    if (bucket_count == '0) begin
      eff = HW'(1);
    end else if (HW'(bucket_count) > HW'(BUCKETS)) begin
      eff = HW'(BUCKETS);
    end else begin
      eff = HW'(bucket_count);
    end
  end

  // restoring remainder, one quotient bit per cycle
  assign eff_sh = (HW+SumW)'(eff) << mod_sh;
  assign hsum_rem = ((HW+SumW)'(hsum) >= eff_sh) ? hsum - eff_sh[HW-1:0] : hsum;

  assign dist_eff = (item.distance < min_distance) ? min_distance : item.distance;
  assign add_sum = {1'b0, rd_total} + (TotalW + 1)'(dist_eff);
  assign sat_total = add_sum[TotalW] ? '1 : add_sum[TotalW-1:0];
  assign key_match = (rd_key == item.key);
  assign node_wr_addr = found ? ptr[AW-1:0] : nodes_used[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    head_rd_en = 1'b0;
    head_wr_en = 1'b0;
    node_rd_en = 1'b0;
    node_wr_en = 1'b0;
    node_key_en = 1'b0;
    case (state)
      S_IDLE: if (in_ch.valid && !clearing && !out_valid) state_next = S_HASH;
      S_HASH: state_next = S_MOD;
      S_MOD: if (mod_sh == '0) state_next = S_HEAD_RD;
      S_HEAD_RD: begin
        head_rd_en = 1'b1;
        state_next = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: state_next = S_NODE_RD;
      S_NODE_RD: begin
        if (ptr >= LW'(NODES) || steps >= LW'(NODES)) begin
          state_next = S_WRITE;
        end else begin
          node_rd_en = 1'b1;
          state_next = S_NODE_WAIT;
        end
      end
      S_NODE_WAIT: state_next = S_CHECK;
      S_CHECK: state_next = key_match ? S_WRITE : S_NODE_RD;
      S_WRITE: begin
        state_next = S_DONE;
        if (item.operation == OP_ADD) begin
          if (found) begin
            node_wr_en = 1'b1;
          end else if (nodes_used < LW'(NODES)) begin
            node_wr_en = 1'b1;
            node_key_en = 1'b1;
            head_wr_en = 1'b1;
          end
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE) && !clearing && !out_valid;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= {in_ch.operation, in_ch.id_high, in_ch.id_mid, in_ch.id_low, in_ch.distance};
        found <= 1'b0;
        steps <= '0;
      end
      S_HASH: begin
        hsum <= HW'({2'b00, item.key.id_mid[15:8]} + {2'b00, item.key.id_mid[7:0]}
                    + {2'b00, item.key.id_low[15:8]} + {2'b00, item.key.id_low[7:0]});
        new_total <= TotalW'(dist_eff);
        mod_sh <= 4'(SumW - 1);
      end
      S_MOD: begin
        hsum <= hsum_rem;
        bucket <= hsum_rem[BW-1:0];
        mod_sh <= mod_sh - 1'b1;
      end
      S_HEAD_WAIT: begin
        ptr <= head_rd_data;
        head_val <= head_rd_data;
      end
      S_CHECK: begin
        if (key_match) begin
          found <= 1'b1;
          new_total <= sat_total;
        end else begin
          ptr <= rd_link;
          steps <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_WRITE && head_wr_en) begin
        nodes_used <= nodes_used + 1'b1;
      end
      if (state == S_WRITE) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      if (item.operation == OP_QUERY) begin
        out_item.status <= found ? ST_OK : ST_NOT_FOUND;
        out_item.total <= found ? rd_total : '0;
      end else if (found) begin
        out_item.status <= ST_OK;
        out_item.total <= new_total;
      end else if (nodes_used < LW'(NODES)) begin
        out_item.status <= ST_OK;
        out_item.total <= TotalW'(dist_eff);
      end else begin
        out_item.status <= ST_FULL;
        out_item.total <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.status = out_item.status;
  assign out_ch.total = out_item.total;
endmodule
